// ----- hdl/mrst_pkg.sv -----
// Shared types, constants and state encoding for the slimmest spanning tree block.
`timescale 1ns / 1ps

package mrst_pkg;

    localparam int VTX_W = 9;
    localparam int WGT_W = 32;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    typedef struct packed {
        logic [8:0]  end_a;
        logic [8:0]  end_b;
        logic [31:0] weight;
        logic        last_edge;
    } in_word_t;

    typedef struct packed {
        logic        connected;
        logic [31:0] min_range;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_PASS_INIT,
        ST_EDGE_RD,
        ST_FIND,
        ST_JOIN,
        ST_PASS_END,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sort_start;
        logic sort_read;
        logic sort_step;
        logic pass_start;
        logic init_step;
        logic edge_read;
        logic find_step;
        logic join_step;
        logic pass_end;
        logic out_done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sort_done;
        logic init_done;
        logic pass_stop;
        logic all_done;
        logic edge_skip;
        logic find_done;
        logic single;
    } stat_t;

endpackage

// ----- hdl/mrst_ctrl.sv -----
// Controller state machine sequencing load, sort and Kruskal passes.
`timescale 1ns / 1ps

module mrst_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last_edge,
    input  logic            out_stall,
    input  mrst_pkg::stat_t stat,
    output mrst_pkg::cmd_t  cmd,
    output logic            in_stall,
    output logic            out_valid
);

    mrst_pkg::state_t state_reg;
    mrst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrst_pkg::ST_LOAD:
            begin
                if (in_valid && last_edge)
                begin
                    state_next = mrst_pkg::ST_SORT_RD;
                end
            end
            mrst_pkg::ST_SORT_RD:
            begin
                if (stat.single)
                begin
                    state_next = mrst_pkg::ST_OUT;
                end
                else if (stat.sort_done)
                begin
                    state_next = mrst_pkg::ST_PASS_INIT;
                end
                else
                begin
                    state_next = mrst_pkg::ST_SORT_CMP;
                end
            end
            mrst_pkg::ST_SORT_CMP:
            begin
                state_next = mrst_pkg::ST_SORT_RD;
            end
            mrst_pkg::ST_PASS_INIT:
            begin
                if (stat.all_done)
                begin
                    state_next = mrst_pkg::ST_OUT;
                end
                else if (stat.init_done)
                begin
                    state_next = mrst_pkg::ST_EDGE_RD;
                end
            end
            mrst_pkg::ST_EDGE_RD:
            begin
                if (stat.pass_stop)
                begin
                    state_next = mrst_pkg::ST_PASS_END;
                end
                else
                begin
                    state_next = mrst_pkg::ST_FIND;
                end
            end
            mrst_pkg::ST_FIND:
            begin
                if (stat.edge_skip)
                begin
                    state_next = mrst_pkg::ST_EDGE_RD;
                end
                else if (stat.find_done)
                begin
                    state_next = mrst_pkg::ST_JOIN;
                end
            end
            mrst_pkg::ST_JOIN:
            begin
                state_next = mrst_pkg::ST_EDGE_RD;
            end
            mrst_pkg::ST_PASS_END:
            begin
                state_next = mrst_pkg::ST_PASS_INIT;
            end
            mrst_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = mrst_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mrst_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            mrst_pkg::ST_LOAD:
            begin
                in_stall        = 1'b0;
                cmd.load        = in_valid;
                cmd.sort_start  = in_valid && last_edge;
            end
            mrst_pkg::ST_SORT_RD:
            begin
                cmd.sort_read = 1'b1;
                cmd.pass_start = stat.sort_done;
            end
            mrst_pkg::ST_SORT_CMP:
            begin
                cmd.sort_step = 1'b1;
            end
            mrst_pkg::ST_PASS_INIT:
            begin
                cmd.init_step = 1'b1;
            end
            mrst_pkg::ST_EDGE_RD:
            begin
                cmd.edge_read = 1'b1;
            end
            mrst_pkg::ST_FIND:
            begin
                cmd.find_step = 1'b1;
            end
            mrst_pkg::ST_JOIN:
            begin
                cmd.join_step = 1'b1;
            end
            mrst_pkg::ST_PASS_END:
            begin
                cmd.pass_end = 1'b1;
            end
            mrst_pkg::ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_done = !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/mrst_dpath.sv -----
// Datapath: edge memory, insertion sort, union-find tables and range tracking.
`timescale 1ns / 1ps

module mrst_dpath
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrst_pkg::in_word_t  in_word,
    input  logic [8:0]          vertex_count,
    input  mrst_pkg::cmd_t      cmd,
    output mrst_pkg::stat_t     stat,
    output mrst_pkg::out_word_t out_word
);

    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int E_W   = 2 * mrst_pkg::VTX_W + mrst_pkg::WGT_W;

    // Edge memory, one read port: sort reads and pass reads share it.
    logic [E_W-1:0]   edge_mem [MAX_EDGES];
    logic [E_W-1:0]   rd_data_reg;
    logic [EA_W-1:0]  rd_addr;
    logic             rd_en;
    logic             mem_we;
    logic [EA_W-1:0]  wr_addr;
    logic [E_W-1:0]   wr_data;

    // Union-find tables with registered reads.
    logic [VA_W-1:0]  parent_mem [MAX_VERTICES];
    logic [VC_W-1:0]  size_mem   [MAX_VERTICES];
    logic [VA_W-1:0]  par_rd_reg;
    logic [VA_W-1:0]  par_raddr;
    logic             par_we;
    logic [VA_W-1:0]  par_waddr;
    logic [VA_W-1:0]  par_wdata;
    logic             size_we;
    logic [VA_W-1:0]  size_waddr;
    logic [VC_W-1:0]  size_wdata;
    logic [VC_W-1:0]  size_a_reg;
    logic [VC_W-1:0]  size_b_reg;

    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] idx_reg;      // sort outer index / pass start
    logic [CNT_W-1:0] pos_reg;      // sort inner index / pass edge
    logic [E_W-1:0]   key_reg;
    logic             key_phase_reg;
    logic [VC_W-1:0]  n_reg;
    logic [VC_W-1:0]  joins_reg;
    logic [VC_W-1:0]  init_reg;
    logic [VA_W-1:0]  xa_reg;
    logic [VA_W-1:0]  xb_reg;
    logic             da_reg;
    logic             db_reg;
    logic             hop_reg;      // par_rd_reg holds the grandparent
    logic             first_find_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [32:0]      best_reg;

    logic [8:0]       vc_eff;
    logic [8:0]       ea;
    logic [8:0]       eb;
    logic signed [31:0] ew;
    logic signed [31:0] kw;
    logic             bad;
    logic             find_act;
    logic [VA_W-1:0]  cur_x;

    assign ea = rd_data_reg[E_W-1 -: 9];
    assign eb = rd_data_reg[E_W-10 -: 9];
    assign ew = rd_data_reg[31:0];
    assign kw = key_reg[31:0];

    // A find cycle that walks the path of the root not yet found.
    assign find_act = cmd.find_step && !first_find_reg && !bad && !(da_reg && db_reg);
    assign cur_x    = da_reg ? xb_reg : xa_reg;

    always_comb
    begin
        vc_eff = (vertex_count == 9'd0) ? 9'd1 : vertex_count;
    end

    // Read address: the key visit reads element pos, later visits read pos-1.
    always_comb
    begin
        if (cmd.sort_read)
        begin
            rd_addr = key_phase_reg ? EA_W'(pos_reg - CNT_W'(1)) : EA_W'(pos_reg);
        end
        else
        begin
            rd_addr = EA_W'(pos_reg);
        end
    end

    assign rd_en = cmd.sort_read || cmd.edge_read;

    // Memory write: loading, shifting during sort, or placing the key.
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = EA_W'(pos_reg);
        wr_data = rd_data_reg;
        if (cmd.load && (total_reg < CNT_W'(MAX_EDGES)))
        begin
            mem_we  = 1'b1;
            wr_addr = EA_W'(total_reg);
            wr_data = {in_word.end_a, in_word.end_b, in_word.weight};
        end
        else if (cmd.sort_step && key_phase_reg)
        begin
            mem_we = 1'b1;
            if ((pos_reg != '0) && ($signed(ew) > kw))
            begin
                wr_data = rd_data_reg;
            end
            else
            begin
                wr_data = key_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= edge_mem[rd_addr];
        end
    end

    logic [CNT_W-1:0] total_now;
    assign total_now = total_reg;

    always_comb
    begin
        stat.single    = cmd.sort_read && (n_reg == VC_W'(1));
        stat.sort_done = (idx_reg >= total_now);
        stat.init_done = (init_reg == n_reg);
        stat.all_done  = (idx_reg >= total_now);
        stat.pass_stop = (pos_reg >= total_now) || (joins_reg == n_reg - VC_W'(1));
        bad = (ea == 9'd0) || (eb == 9'd0) || (int'(ea) > int'(n_reg)) ||
              (int'(eb) > int'(n_reg));
        stat.edge_skip = cmd.find_step && (bad || (da_reg && db_reg && xa_reg == xb_reg));
        stat.find_done = da_reg && db_reg;
    end

    // Parent read: the first find cycle starts at endpoint a; a finished root
    // check on side a moves on to side b.
    always_comb
    begin
        par_raddr = cur_x;
        if (cmd.find_step && first_find_reg)
        begin
            par_raddr = VA_W'(ea - 9'd1);
        end
        else if (find_act)
        begin
            if (hop_reg || (par_rd_reg != cur_x))
            begin
                par_raddr = par_rd_reg;
            end
            else
            begin
                par_raddr = xb_reg;
            end
        end
    end

    always_comb
    begin
        par_we     = 1'b0;
        par_waddr  = VA_W'(init_reg);
        par_wdata  = VA_W'(init_reg);
        size_we    = 1'b0;
        size_waddr = VA_W'(init_reg);
        size_wdata = VC_W'(1);
        if (cmd.init_step && !stat.init_done)
        begin
            par_we  = 1'b1;
            size_we = 1'b1;
        end
        else if (find_act && hop_reg)
        begin
            // Path halving: point the node at its grandparent.
            par_we    = 1'b1;
            par_waddr = cur_x;
            par_wdata = par_rd_reg;
        end
        else if (cmd.join_step)
        begin
            par_we     = 1'b1;
            size_we    = 1'b1;
            size_wdata = size_a_reg + size_b_reg;
            if (size_a_reg < size_b_reg)
            begin
                par_waddr  = xa_reg;
                par_wdata  = xb_reg;
                size_waddr = xb_reg;
            end
            else
            begin
                par_waddr  = xb_reg;
                par_wdata  = xa_reg;
                size_waddr = xa_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        par_rd_reg <= parent_mem[par_raddr];
        size_a_reg <= size_mem[xa_reg];
        size_b_reg <= size_mem[xb_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            key_phase_reg <= 1'b0;
            n_reg         <= VC_W'(1);
            joins_reg     <= '0;
            init_reg      <= '0;
            xa_reg        <= '0;
            xb_reg        <= '0;
            da_reg        <= 1'b0;
            db_reg        <= 1'b0;
            hop_reg       <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            best_reg      <= '1;
        end
        else
        begin
            if (cmd.load && (total_reg < CNT_W'(MAX_EDGES)))
            begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (cmd.sort_start)
            begin
                n_reg <= (int'(vc_eff) > MAX_VERTICES) ? VC_W'(MAX_VERTICES) : VC_W'(vc_eff);
                idx_reg       <= CNT_W'(1);
                pos_reg       <= CNT_W'(1);
                key_phase_reg <= 1'b0;
                best_reg      <= '1;
            end
            // Insertion sort: first visit of an index latches the key.
            if (cmd.sort_step)
            begin
                if (!key_phase_reg)
                begin
                    key_phase_reg <= 1'b1;
                end
                else if ((pos_reg != '0) && ($signed(ew) > kw))
                begin
                    pos_reg <= pos_reg - CNT_W'(1);
                end
                else
                begin
                    key_phase_reg <= 1'b0;
                    idx_reg       <= idx_reg + CNT_W'(1);
                    pos_reg       <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.pass_start)
            begin
                idx_reg  <= '0;
                init_reg <= '0;
            end
            if (cmd.init_step && !stat.init_done)
            begin
                init_reg <= init_reg + VC_W'(1);
            end
            if (cmd.init_step && stat.init_done)
            begin
                pos_reg   <= idx_reg;
                joins_reg <= '0;
            end
            if (cmd.edge_read)
            begin
                da_reg <= 1'b0;
                db_reg <= 1'b0;
                pos_reg <= pos_reg + CNT_W'(1);
            end
            if (cmd.find_step && first_find_reg)
            begin
                xa_reg  <= VA_W'(ea - 9'd1);
                xb_reg  <= VA_W'(eb - 9'd1);
                hop_reg <= 1'b0;
            end
            else if (find_act)
            begin
                if (hop_reg)
                begin
                    hop_reg <= 1'b0;
                    if (!da_reg)
                    begin
                        xa_reg <= par_rd_reg;
                    end
                    else
                    begin
                        xb_reg <= par_rd_reg;
                    end
                end
                else if (par_rd_reg == cur_x)
                begin
                    if (!da_reg)
                    begin
                        da_reg <= 1'b1;
                    end
                    else
                    begin
                        db_reg <= 1'b1;
                    end
                end
                else
                begin
                    hop_reg <= 1'b1;
                end
            end
            if (cmd.join_step)
            begin
                joins_reg <= joins_reg + VC_W'(1);
                if (joins_reg == '0 || ew < lo_reg)
                begin
                    lo_reg <= ew;
                end
                if (joins_reg == '0 || ew > hi_reg)
                begin
                    hi_reg <= ew;
                end
            end
            if (cmd.pass_end)
            begin
                idx_reg  <= idx_reg + CNT_W'(1);
                init_reg <= '0;
                if ((joins_reg == n_reg - VC_W'(1)) &&
                    ({1'b0, 32'(hi_reg - lo_reg)} < best_reg))
                begin
                    best_reg <= {1'b0, 32'(hi_reg - lo_reg)};
                end
            end
            if (stat.single)
            begin
                best_reg <= '0;
            end
            if (cmd.out_done)
            begin
                total_reg <= '0;
                best_reg  <= '1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_step && !key_phase_reg)
        begin
            key_reg <= rd_data_reg;
        end
    end

    // Roots start at the endpoints in the first find cycle after an edge read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_find_reg <= 1'b0;
        end
        else
        begin
            first_find_reg <= cmd.edge_read;
        end
    end

    always_comb
    begin
        out_word.connected = !best_reg[32];
        out_word.min_range = best_reg[32] ? 32'd0 : best_reg[31:0];
    end

endmodule

// ----- hdl/min_range_spanning_tree.sv -----
// Top level: slimmest spanning tree over loaded edges.
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_word  (end_a, end_b, weight, last_edge)
//   out     | output    | out_valid/out_stall | out_word (connected, min_range)
//   cfg     | input     | APB write/read      | vertex_count at address 0
// Each edge word is taken with one memory write while the store has room. After the last
// edge an insertion sort runs, then one Kruskal pass per start position: the union-find
// tables are set up, then each edge gets root finds for both ends, with path halving on
// each hop, and a join if the roots differ; the pass is scored at its end.
// Reset clears the edge count and control; the result word waits while out_stall is high.
`timescale 1ns / 1ps

module min_range_spanning_tree
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mrst_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output mrst_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    mrst_pkg::cmd_t  cmd;
    mrst_pkg::stat_t stat;
    logic [8:0]      vertex_count_reg;

    assign pready = 1'b1;
    assign prdata = {23'd0, vertex_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 9'd1;
        end
        else if (psel && penable && pwrite && (paddr == mrst_pkg::REG_VERTEX_COUNT))
        begin
            vertex_count_reg <= pwdata[8:0];
        end
    end

    mrst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (in_word.last_edge),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    mrst_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (in_word),
        .vertex_count (vertex_count_reg),
        .cmd          (cmd),
        .stat         (stat),
        .out_word     (out_word)
    );

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result changed while stalled");

    a_range_zero_unconnected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.connected |-> out_word.min_range == 32'd0)
        else $error("range nonzero without a spanning tree");

endmodule

// ----- tb/min_range_spanning_tree_test.sv -----
// Self-checking testbench for the slimmest spanning tree block.
`timescale 1ns / 1ps

module min_range_spanning_tree_test;

    localparam int NUM_VERTICES = 256;
    localparam int EDGE_SLOTS = 1024;
    localparam int STALL_LIMIT = 4000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    mrst_pkg::in_word_t in_word;
    logic out_valid;
    logic out_stall;
    mrst_pkg::out_word_t out_word;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    mrst_pkg::in_word_t loaded_edges[$];
    mrst_pkg::out_word_t pending_results[$];
    logic [8:0] vertex_reg;
    int send_idle_pct;
    int stall_pct;
    int error_count;
    int quiet_cycles;

    min_range_spanning_tree u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Range of the slimmest spanning tree over the loaded edges.
    function automatic mrst_pkg::out_word_t slimmest_tree(input mrst_pkg::in_word_t edges[$],
                                                         input logic [8:0] vc);
        mrst_pkg::out_word_t res;
        mrst_pkg::in_word_t sorted[$];
        mrst_pkg::in_word_t key;
        int n;
        int j;
        int joins;
        int ra;
        int rb;
        int t;
        int parent[NUM_VERTICES];
        int size_of[NUM_VERTICES];
        longint lo;
        longint hi;
        longint wv;
        longint best;
        begin
            n = vc;
            if (n == 0)
                n = 1;
            if (n > NUM_VERTICES)
                n = NUM_VERTICES;
            best = -1;
            if (n == 1)
                best = 0;
            else
            begin
                sorted = edges;
                for (int i = 1; i < sorted.size(); i++)
                begin
                    key = sorted[i];
                    j = i;
                    while (j > 0 && $signed(sorted[j-1].weight) > $signed(key.weight))
                    begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = key;
                end
                for (int s = 0; s < sorted.size(); s++)
                begin
                    for (int v = 0; v < n; v++)
                    begin
                        parent[v] = v;
                        size_of[v] = 1;
                    end
                    joins = 0;
                    lo = 0;
                    hi = 0;
                    for (int k = s; k < sorted.size() && joins < n - 1; k++)
                    begin
                        if (sorted[k].end_a == 0 || sorted[k].end_b == 0 ||
                            sorted[k].end_a > n || sorted[k].end_b > n)
                            continue;
                        ra = sorted[k].end_a - 1;
                        while (parent[ra] != ra)
                            ra = parent[ra];
                        rb = sorted[k].end_b - 1;
                        while (parent[rb] != rb)
                            rb = parent[rb];
                        if (ra == rb)
                            continue;
                        if (size_of[ra] < size_of[rb])
                        begin
                            t = ra;
                            ra = rb;
                            rb = t;
                        end
                        parent[rb] = ra;
                        size_of[ra] += size_of[rb];
                        wv = longint'($signed(sorted[k].weight));
                        if (joins == 0 || wv < lo)
                            lo = wv;
                        if (joins == 0 || wv > hi)
                            hi = wv;
                        joins++;
                    end
                    if (joins == n - 1 && (best < 0 || hi - lo < best))
                        best = hi - lo;
                end
            end
            res.connected = (best >= 0);
            res.min_range = (best >= 0) ? best[31:0] : 32'd0;
            return res;
        end
    endfunction

    task automatic send_edge(input logic [8:0] a, input logic [8:0] b,
                             input logic [31:0] w, input logic last);
        mrst_pkg::in_word_t e;
        begin
            e.end_a = a;
            e.end_b = b;
            e.weight = w;
            e.last_edge = last;
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_word <= e;
            do
                @(posedge clk);
            while (in_stall);
            if (loaded_edges.size() < EDGE_SLOTS)
                loaded_edges = {loaded_edges, e};
            if (last)
            begin
                pending_results = {pending_results, slimmest_tree(loaded_edges, vertex_reg)};
                loaded_edges.delete();
            end
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic write_vertices(input logic [8:0] value);
        begin
            wait_idle();
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= mrst_pkg::REG_VERTEX_COUNT;
            pwdata <= {23'd0, value};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            vertex_reg = value;
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        begin
            // Single vertex after reset: any edge gives a connected tree of range zero.
            send_edge(9'd5, 9'd7, 32'h1234_5678, 1'b1);
            write_vertices(9'd0);
            send_edge(9'd1, 9'd1, 32'h8000_0000, 1'b1);
            // Widest possible range.
            write_vertices(9'd3);
            send_edge(9'd1, 9'd2, 32'h8000_0000, 1'b0);
            send_edge(9'd0, 9'd3, 32'd0, 1'b0);
            send_edge(9'd3, 9'd3, 32'd1, 1'b0);
            send_edge(9'd511, 9'd2, 32'd2, 1'b0);
            send_edge(9'd3, 9'd2, 32'h7FFF_FFFF, 1'b1);
            // Disconnected graph.
            send_edge(9'd1, 9'd2, 32'd10, 1'b0);
            send_edge(9'd2, 9'd1, 32'd20, 1'b1);
            // A cycle where a narrower tree exists.
            send_edge(9'd1, 9'd2, 32'hFFFF_FFF0, 1'b0);
            send_edge(9'd2, 9'd3, 32'd100, 1'b0);
            send_edge(9'd3, 9'd1, 32'd105, 1'b0);
            send_edge(9'd1, 9'd2, 32'd101, 1'b1);
            // Count above the vertex limit saturates.
            write_vertices(9'd511);
            send_edge(9'd256, 9'd1, 32'd3, 1'b0);
            send_edge(9'd257, 9'd2, 32'd4, 1'b1);
            write_vertices(9'd256);
            send_edge(9'd256, 9'd255, 32'd0, 1'b1);
        end
    endtask

    task automatic test_large_graphs();
        begin
            // A chain over every vertex.
            for (int i = 1; i < NUM_VERTICES; i++)
                send_edge(i[8:0], 9'(i + 1), $urandom, i == NUM_VERTICES - 1);
            // Overfilled store: the dropped last word still starts the computation.
            write_vertices(9'd2);
            for (int i = 0; i < EDGE_SLOTS + 6; i++)
                send_edge(9'd1, 9'd2, 32'(i * 4 - 2000), i == EDGE_SLOTS + 5);
        end
    endtask

    task automatic test_random_graphs(input int idle_pct, input int stall_level,
                                      input int word_budget);
        int sent;
        int n;
        int edge_count;
        int spread;
        logic [31:0] base;
        logic [8:0] a;
        logic [8:0] b;
        begin
            send_idle_pct = idle_pct;
            stall_pct = stall_level;
            sent = 0;
            while (sent < word_budget)
            begin
                if ($urandom_range(3) == 0)
                begin
                    case ($urandom_range(9))
                        0: write_vertices(9'($urandom_range(1)));
                        1: write_vertices(9'($urandom_range(511)));
                        default: write_vertices(9'($urandom_range(8, 2)));
                    endcase
                end
                n = (vertex_reg == 0) ? 1 : (vertex_reg > 256 ? 256 : vertex_reg);
                edge_count = $urandom_range(16, 1);
                spread = $urandom_range(2);
                base = $urandom;
                for (int k = 0; k < edge_count; k++)
                begin
                    if ($urandom_range(9) == 0 || n > 16)
                    begin
                        a = 9'($urandom);
                        b = 9'($urandom);
                    end
                    else
                    begin
                        a = 9'($urandom_range(n, 1));
                        b = 9'($urandom_range(n, 1));
                    end
                    send_edge(a, b,
                              spread == 0 ? base + $urandom_range(40) :
                              spread == 1 ? 32'($signed($urandom_range(200)) - 100) : $urandom,
                              k == edge_count - 1);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result connected=%0b min_range=%0h",
                       out_word.connected, out_word.min_range);
                error_count++;
            end
            else
            begin
                if (out_word.connected !== pending_results[0].connected)
                begin
                    $error("connected: expected %0b, actual %0b",
                           pending_results[0].connected, out_word.connected);
                    error_count++;
                end
                if (out_word.min_range !== pending_results[0].min_range)
                begin
                    $error("min_range: expected %0h, actual %0h",
                           pending_results[0].min_range, out_word.min_range);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[min_range_spanning_tree] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vertex_reg = 9'd1;
        send_idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_large_graphs();
        test_random_graphs(0, 0, 125);
        test_random_graphs(46, 0, 125);
        test_random_graphs(0, 46, 125);
        test_random_graphs(8, 8, 125);
        wait_idle();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[min_range_spanning_tree] OK");
        else
            $display("[min_range_spanning_tree] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mrst_pkg.sv
hdl/mrst_ctrl.sv
hdl/mrst_dpath.sv
hdl/min_range_spanning_tree.sv
tb/min_range_spanning_tree_test.sv
